[hw/rtl/csl_pkg.sv]
// Shared types, codes and character classes of the character stream lexer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csl_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] KIND_ID     = 3'd0;
	localparam logic [2:0] KIND_NUM    = 3'd1;
	localparam logic [2:0] KIND_SYMBOL = 3'd2;
	localparam logic [2:0] KIND_ERROR  = 3'd3;
	localparam logic [2:0] KIND_STRING = 3'd4;

	localparam logic [1:0] ERR_NONE         = 2'd0;
	localparam logic [1:0] ERR_INVALID      = 2'd1;
	localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_WORD   = 3'b010,
		MODE_STRING = 3'b100
	} lex_mode_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] lex_char;
		logic       char_valid;
		logic [1:0] error_code;
		logic       last;
	} result_t;

	// One input character worth of results: one or two
	typedef struct packed {
		result_t first;
		result_t second;
		logic    two;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {8'h20, [8'h09:8'h0D]});
	endfunction

	function automatic logic is_symbol(input logic [7:0] c);
		return (c inside {8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h7B, 8'h7D,
			8'h3B});
	endfunction

endpackage
`default_nettype wire

[hw/rtl/char_stream_lexer_unit.sv]
// An accepted character's first result is written into the queue, then into the back end's output register.
// Throughput: one character per cycle while the queue is not full; a character that ends a word
// and is itself a symbol or an invalid character yields two results, sent one after the other.
// A four-entry queue between front and back end absorbs such bursts.
// Reset: asynchronous, active low; mode returns to idle and the queue empties.
// Top level of the character stream lexer; depends on csl_pkg, csl_front, csl_queue, csl_back.
`timescale 1ns / 1ps
`default_nettype none
module char_stream_lexer_unit #(
	parameter int QUEUE_DEPTH = csl_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output wire logic       in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       end_of_input,
	output wire logic       out_valid,
	input  wire logic       out_ready,
	output wire logic [2:0] kind,
	output wire logic [7:0] lex_char,
	output wire logic       char_valid,
	output wire logic [1:0] error_code,
	output wire logic       last
);

	csl_pkg::push_t   push;
	csl_pkg::entry_t  head;
	csl_pkg::result_t res;
	logic             full, not_empty, pop, accept;

	assign in_ready = !full;
	assign accept   = in_valid && !full;

	csl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.accept       (accept),
		.ch           (ch),
		.end_of_input (end_of_input),
		.push         (push)
	);

	csl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	csl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res       (res)
	);

	assign kind       = res.kind;
	assign lex_char   = res.lex_char;
	assign char_valid = res.char_valid;
	assign error_code = res.error_code;
	assign last       = res.last;

endmodule
`default_nettype wire

[hw/rtl/csl_front.sv]
// Front end: accepts characters, classifies them and tracks the token mode.
// Depends on csl_pkg; pushes result entries into csl_queue.
`timescale 1ns / 1ps
`default_nettype none
module csl_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             accept,
	input  wire logic [7:0]       ch,
	input  wire logic             end_of_input,
	output csl_pkg::push_t        push
);

	csl_pkg::lex_mode_t mode_q, mode_d;
	logic               num_q, num_d;

	logic               eoi;
	logic               word_char;
	logic [2:0]         wkind;
	csl_pkg::result_t   end_res;
	csl_pkg::result_t   st_res;
	logic               st_has;
	csl_pkg::lex_mode_t st_mode;
	logic               st_num;
	csl_pkg::result_t   r0, r1;
	logic               has0, two;

	assign eoi       = end_of_input || (ch == csl_pkg::CHAR_NUL);
	assign word_char = csl_pkg::is_letter(ch) || csl_pkg::is_digit(ch) ||
		(ch == csl_pkg::CHAR_DOT);
	assign wkind     = num_q ? csl_pkg::KIND_NUM : csl_pkg::KIND_ID;

	always_comb begin
		end_res            = '0;
		end_res.kind       = wkind;
		end_res.error_code = csl_pkg::ERR_NONE;
		end_res.last       = 1'b1;
	end

	// Handle a character with no token open
	always_comb begin
		st_res          = '0;
		st_res.lex_char = ch;
		st_res.char_valid = 1'b1;
		st_has          = 1'b0;
		st_mode         = csl_pkg::MODE_IDLE;
		st_num          = num_q;
		if (csl_pkg::is_letter(ch) || csl_pkg::is_digit(ch)) begin
			st_num      = csl_pkg::is_digit(ch);
			st_mode     = csl_pkg::MODE_WORD;
			st_has      = 1'b1;
			st_res.kind = csl_pkg::is_digit(ch) ? csl_pkg::KIND_NUM : csl_pkg::KIND_ID;
		end else if (ch == csl_pkg::CHAR_QUOTE) begin
			st_mode = csl_pkg::MODE_STRING;
		end else if (csl_pkg::is_symbol(ch)) begin
			st_has      = 1'b1;
			st_res.kind = csl_pkg::KIND_SYMBOL;
			st_res.last = 1'b1;
		end else if (!csl_pkg::is_space(ch)) begin
			st_has            = 1'b1;
			st_res.kind       = csl_pkg::KIND_ERROR;
			st_res.error_code = csl_pkg::ERR_INVALID;
			st_res.last       = 1'b1;
		end
	end

	always_comb begin
		r0     = '0;
		r1     = '0;
		has0   = 1'b0;
		two    = 1'b0;
		mode_d = mode_q;
		num_d  = num_q;
		if (eoi) begin
			mode_d = csl_pkg::MODE_IDLE;
			num_d  = 1'b0;
			case (mode_q)
				csl_pkg::MODE_WORD: begin
					has0 = 1'b1;
					r0   = end_res;
				end
				csl_pkg::MODE_STRING: begin
					has0          = 1'b1;
					r0.kind       = csl_pkg::KIND_ERROR;
					r0.error_code = csl_pkg::ERR_UNTERMINATED;
					r0.last       = 1'b1;
				end
				default: begin
					has0 = 1'b0;
				end
			endcase
		end else begin
			case (mode_q)
				csl_pkg::MODE_WORD: begin
					has0 = 1'b1;
					if (word_char) begin
						r0.kind       = wkind;
						r0.lex_char   = ch;
						r0.char_valid = 1'b1;
					end else begin
						r0     = end_res;
						r1     = st_res;
						two    = st_has;
						mode_d = st_mode;
						num_d  = st_num;
					end
				end
				csl_pkg::MODE_STRING: begin
					has0    = 1'b1;
					r0.kind = csl_pkg::KIND_STRING;
					if (ch == csl_pkg::CHAR_QUOTE) begin
						r0.last = 1'b1;
						mode_d  = csl_pkg::MODE_IDLE;
					end else begin
						r0.lex_char   = ch;
						r0.char_valid = 1'b1;
					end
				end
				default: begin
					has0   = st_has;
					r0     = st_res;
					mode_d = st_mode;
					num_d  = st_num;
				end
			endcase
		end
	end

	assign push.push         = accept && in_valid && has0;
	assign push.entry.first  = r0;
	assign push.entry.second = r1;
	assign push.entry.two    = two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csl_pkg::MODE_IDLE;
			num_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			num_q  <= num_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/csl_queue.sv]
// Short queue of result entries between the front and back ends.
// Depends on csl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csl_queue #(
	parameter int DEPTH = csl_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire csl_pkg::push_t   push,
	input  wire logic             pop,
	output wire logic             full,
	output wire logic             not_empty,
	output csl_pkg::entry_t       head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	csl_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push.push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/csl_back.sv]
// Back end: holds one entry in an output register and sends its results in order.
// Depends on csl_pkg; pops entries from csl_queue.
`timescale 1ns / 1ps
`default_nettype none
module csl_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             not_empty,
	input  wire csl_pkg::entry_t  head,
	output wire logic             pop,
	input  wire logic             out_ready,
	output wire logic             out_valid,
	output csl_pkg::result_t      res
);

	logic            busy_q;
	logic            idx_q;
	csl_pkg::entry_t entry_q;
	logic            done;

	assign done      = out_ready && busy_q && (!entry_q.two || idx_q);
	assign pop       = not_empty && (!busy_q || done);
	assign out_valid = busy_q;
	assign res       = idx_q ? entry_q.second : entry_q.first;

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 1'b0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/csl_checker.sv]
// Port-level checks of the character stream lexer, bound to its top level.
// Depends on csl_pkg and char_stream_lexer_unit.
`timescale 1ns / 1ps
`default_nettype none
module csl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] kind,
	input wire logic [7:0] lex_char,
	input wire logic       char_valid,
	input wire logic [1:0] error_code,
	input wire logic       last
);

	// Hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lex_char) && $stable(kind))
		else $error("output transaction changed while stalled");

	a_err_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != csl_pkg::KIND_ERROR) |-> error_code == csl_pkg::ERR_NONE)
		else $error("error code on a non-error token");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> last && (lex_char == 8'h00))
		else $error("bare marker without last or with a character");

	a_unterm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == csl_pkg::ERR_UNTERMINATED) |-> !char_valid && last)
		else $error("malformed unterminated-string error");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == csl_pkg::KIND_SYMBOL) || (kind == csl_pkg::KIND_ERROR))
		|-> last)
		else $error("symbol or error token not closed in one transaction");

endmodule

bind char_stream_lexer_unit csl_checker u_csl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.lex_char   (lex_char),
	.char_valid (char_valid),
	.error_code (error_code),
	.last       (last)
);
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for char_stream_lexer_unit: directed table, then random streams.
// Expected tokens come from a behavioral lexer kept in step with each accepted character, or from typed rows.
// Depends on csl_pkg and the char_stream_lexer_unit RTL.
`timescale 1ns / 1ps
module tb;

	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [7:0]       c;
		logic             e;
		logic             typed;
		int               n;
		csl_pkg::result_t r;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] ch;
	logic       end_of_input;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] kind;
	logic [7:0] lex_char;
	logic       char_valid;
	logic [1:0] error_code;
	logic       last;

	char_stream_lexer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.lex_char(lex_char),
		.char_valid(char_valid),
		.error_code(error_code),
		.last(last)
	);

	string              sym_chars = "=+-*/(){};";
	csl_pkg::lex_mode_t lex_mode;
	logic               word_is_num;
	csl_pkg::result_t   step_tokens[$];
	csl_pkg::result_t   pending_tokens[$];
	csl_pkg::result_t   got_token;
	stim_row_t          rows[$];
	int                 fails = 0;
	int                 cycles = 0;
	int                 sent = 0;
	bit                 steady = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic csl_pkg::result_t token_beat(input logic [2:0] k, input logic [7:0] c,
		input logic v, input logic [1:0] err, input logic l);
		csl_pkg::result_t t;
		t.kind = k;
		t.lex_char = c;
		t.char_valid = v;
		t.error_code = err;
		t.last = l;
		return t;
	endfunction

	function automatic logic alnum_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
	endfunction

	function automatic logic sym_char(input logic [7:0] c);
		for (int i = 0; i < sym_chars.len(); i++)
			if (sym_chars[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	// Advance the lexer state by one character and collect the tokens it emits.
	function automatic void lex_step(input logic [7:0] c, input logic e);
		logic [2:0] wkind;
		wkind = word_is_num ? csl_pkg::KIND_NUM : csl_pkg::KIND_ID;
		step_tokens.delete();
		if (e || c == csl_pkg::CHAR_NUL) begin
			if (lex_mode == csl_pkg::MODE_WORD)
				step_tokens.push_back(token_beat(wkind, 8'h00, 1'b0, csl_pkg::ERR_NONE,
					1'b1));
			else if (lex_mode == csl_pkg::MODE_STRING)
				step_tokens.push_back(token_beat(csl_pkg::KIND_ERROR, 8'h00, 1'b0,
					csl_pkg::ERR_UNTERMINATED, 1'b1));
			lex_mode = csl_pkg::MODE_IDLE;
			word_is_num = 1'b0;
			return;
		end
		if (lex_mode == csl_pkg::MODE_WORD) begin
			if (alnum_char(c) || c == csl_pkg::CHAR_DOT) begin
				step_tokens.push_back(token_beat(wkind, c, 1'b1, csl_pkg::ERR_NONE, 1'b0));
				return;
			end
			step_tokens.push_back(token_beat(wkind, 8'h00, 1'b0, csl_pkg::ERR_NONE, 1'b1));
			lex_mode = csl_pkg::MODE_IDLE;
		end else if (lex_mode == csl_pkg::MODE_STRING) begin
			if (c == csl_pkg::CHAR_QUOTE) begin
				lex_mode = csl_pkg::MODE_IDLE;
				step_tokens.push_back(token_beat(csl_pkg::KIND_STRING, 8'h00, 1'b0,
					csl_pkg::ERR_NONE, 1'b1));
			end else begin
				step_tokens.push_back(token_beat(csl_pkg::KIND_STRING, c, 1'b1,
					csl_pkg::ERR_NONE, 1'b0));
			end
			return;
		end
		if (alnum_char(c)) begin
			word_is_num = (c >= "0" && c <= "9");
			lex_mode = csl_pkg::MODE_WORD;
			step_tokens.push_back(token_beat(word_is_num ? csl_pkg::KIND_NUM : csl_pkg::KIND_ID,
				c, 1'b1, csl_pkg::ERR_NONE, 1'b0));
		end else if (c == csl_pkg::CHAR_QUOTE) begin
			lex_mode = csl_pkg::MODE_STRING;
		end else begin
			lex_mode = csl_pkg::MODE_IDLE;
			if (sym_char(c))
				step_tokens.push_back(token_beat(csl_pkg::KIND_SYMBOL, c, 1'b1,
					csl_pkg::ERR_NONE, 1'b1));
			else if (!(c == " " || (c >= 8'd9 && c <= 8'd13)))
				step_tokens.push_back(token_beat(csl_pkg::KIND_ERROR, c, 1'b1,
					csl_pkg::ERR_INVALID, 1'b1));
		end
	endfunction

	task automatic row(input logic [7:0] c, input logic e, input logic typed, input int n,
		input csl_pkg::result_t r);
		stim_row_t s;
		s.c = c;
		s.e = e;
		s.typed = typed;
		s.n = n;
		s.r = r;
		rows.push_back(s);
	endtask

	task automatic pick_char(output logic [7:0] c, output logic e);
		int r;
		int idx;
		r = $urandom_range(0, 99);
		e = 1'b0;
		if (r < 30) begin
			idx = $urandom_range(0, 51);
			c = (idx < 26) ? "A" + 8'(idx) : "a" + 8'(idx - 26);
		end else if (r < 45) begin
			c = "0" + 8'($urandom_range(0, 9));
		end else if (r < 50) begin
			c = csl_pkg::CHAR_DOT;
		end else if (r < 63) begin
			c = sym_chars[$urandom_range(0, 9)];
		end else if (r < 71) begin
			c = ($urandom_range(0, 1) == 0) ? " " : 8'($urandom_range(9, 13));
		end else if (r < 79) begin
			c = csl_pkg::CHAR_QUOTE;
		end else if (r < 92) begin
			c = 8'($urandom_range(0, 255));
		end else if (r < 96) begin
			c = csl_pkg::CHAR_NUL;
		end else begin
			c = 8'($urandom_range(0, 255));
			e = 1'b1;
		end
	endtask

	// Present one character and hold it until the transaction completes.
	task automatic send_char(input logic [7:0] c, input logic e);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 25) ? $urandom_range(1, 4) : 0;
		@(negedge clk);
		while (gap > 0) begin
			in_valid <= 1'b0;
			gap--;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		end_of_input <= e;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Stimulus
	initial begin
		logic [7:0] c;
		logic       e;
		in_valid = 1'b0;
		ch = 8'h00;
		end_of_input = 1'b0;
		arst_n = 1'b0;
		lex_mode = csl_pkg::MODE_IDLE;
		word_is_num = 1'b0;

		row(8'hFF, 1'b1, 1'b1, 0, '0);
		row("=", 1'b0, 1'b1, 1, token_beat(csl_pkg::KIND_SYMBOL, "=", 1'b1,
			csl_pkg::ERR_NONE, 1'b1));
		row(8'hFF, 1'b0, 1'b1, 1, token_beat(csl_pkg::KIND_ERROR, 8'hFF, 1'b1,
			csl_pkg::ERR_INVALID, 1'b1));
		row(8'h80, 1'b0, 1'b1, 1, token_beat(csl_pkg::KIND_ERROR, 8'h80, 1'b1,
			csl_pkg::ERR_INVALID, 1'b1));
		row("A", 1'b0, 1'b0, 0, '0);
		row("z", 1'b0, 1'b0, 0, '0);
		row(".", 1'b0, 1'b0, 0, '0);
		row("9", 1'b0, 1'b0, 0, '0);
		row(";", 1'b0, 1'b0, 0, '0);
		row("0", 1'b0, 1'b0, 0, '0);
		row(8'h01, 1'b0, 1'b0, 0, '0);
		row("a", 1'b0, 1'b0, 0, '0);
		row(" ", 1'b0, 1'b0, 0, '0);
		row("5", 1'b0, 1'b0, 0, '0);
		row(csl_pkg::CHAR_QUOTE, 1'b0, 1'b0, 0, '0);
		row(8'hFF, 1'b0, 1'b0, 0, '0);
		row(csl_pkg::CHAR_NUL, 1'b0, 1'b1, 1,
			token_beat(csl_pkg::KIND_ERROR, 8'h00, 1'b0, csl_pkg::ERR_UNTERMINATED, 1'b1));
		row(csl_pkg::CHAR_QUOTE, 1'b0, 1'b0, 0, '0);
		row(csl_pkg::CHAR_QUOTE, 1'b0, 1'b0, 0, '0);
		row("Q", 1'b0, 1'b0, 0, '0);
		row(csl_pkg::CHAR_NUL, 1'b0, 1'b0, 0, '0);
		row(csl_pkg::CHAR_QUOTE, 1'b0, 1'b0, 0, '0);
		row("x", 1'b1, 1'b1, 1,
			token_beat(csl_pkg::KIND_ERROR, 8'h00, 1'b0, csl_pkg::ERR_UNTERMINATED, 1'b1));
		row(8'h09, 1'b0, 1'b1, 0, '0);
		row("}", 1'b0, 1'b0, 0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			send_char(rows[i].c, rows[i].e);
			lex_step(rows[i].c, rows[i].e);
			if (rows[i].typed) begin
				for (int k = 0; k < rows[i].n; k++)
					pending_tokens.push_back(rows[i].r);
			end else begin
				foreach (step_tokens[k])
					pending_tokens.push_back(step_tokens[k]);
			end
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 150 && i < 250);
			pick_char(c, e);
			send_char(c, e);
			lex_step(c, e);
			foreach (step_tokens[k])
				pending_tokens.push_back(step_tokens[k]);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("char_stream_lexer_unit: match");
		else
			$display("char_stream_lexer_unit: mismatch");
		$finish;
	end

	// Receiver: random back-pressure, one long hold-off to fill the block
	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sent >= 350) begin
				held = 1;
				hold = 80;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				$error("unexpected token: kind %0d char %02h", kind, lex_char);
				fails++;
			end else begin
				got_token = pending_tokens.pop_front();
				if (kind !== got_token.kind) begin
					$error("kind: expected %0d, got %0d", got_token.kind, kind);
					fails++;
				end
				if (lex_char !== got_token.lex_char) begin
					$error("lex_char: expected %02h, got %02h", got_token.lex_char, lex_char);
					fails++;
				end
				if (char_valid !== got_token.char_valid) begin
					$error("char_valid: expected %0d, got %0d", got_token.char_valid,
						char_valid);
					fails++;
				end
				if (error_code !== got_token.error_code) begin
					$error("error_code: expected %0d, got %0d", got_token.error_code,
						error_code);
					fails++;
				end
				if (last !== got_token.last) begin
					$error("last: expected %0d, got %0d", got_token.last, last);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("char_stream_lexer_unit: mismatch");
			$finish;
		end
	end

endmodule
